// File: rtl/core/imi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the Ikeda map iterator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package imi_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int ANG_BITS     = 30;
  localparam int ANG_SHIFT    = ANG_BITS - FRAC_BITS;
  localparam int CORDIC_STEPS = 24;
  localparam int MAX_POINTS   = 64;
  localparam int NUM_W        = 32 + FRAC_BITS;  // dividend |d| << FRAC_BITS
  localparam int DEN_W        = 40;
  localparam int RED_W        = 40;
  localparam int RED_STEPS    = 7;               // 2*pi << 6 .. 2*pi << 0
  localparam int CW           = 34;              // CORDIC vector and angle width

  localparam logic signed [34:0] PI_A      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_A = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_A  = 35'sd6746518852;
  localparam logic [RED_W-1:0]   TWO_PI_R  = 40'd6746518852;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sh026DD3B6A;
  localparam logic signed [65:0] ROT_LIM   = 66'sd4294967295;
  localparam logic signed [65:0] INT_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] INT_MIN_W = -66'sd2147483648;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN_B   = 3'd0;
  localparam logic [2:0] REG_OFFSET_C = 3'd1;
  localparam logic [2:0] REG_PHASE_D  = 3'd2;
  localparam logic [2:0] REG_WARMUP   = 3'd3;
  localparam logic [2:0] REG_POINTS   = 3'd4;

  localparam logic [31:0] GAIN_B_RST   = 32'd15099494;
  localparam logic [31:0] OFFSET_C_RST = 32'd6710886;
  localparam logic [31:0] PHASE_D_RST  = 32'd100663296;
  localparam logic [15:0] WARMUP_RST   = 16'd500;
  localparam logic [6:0]  POINTS_RST   = 7'd64;

  // Datapath operations.
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_SQX   = 4'd2;
  localparam logic [3:0] OP_SQY   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_PHASE = 4'd5;
  localparam logic [3:0] OP_RED   = 4'd6;
  localparam logic [3:0] OP_FOLD  = 4'd7;
  localparam logic [3:0] OP_COR   = 4'd8;
  localparam logic [3:0] OP_ROT0  = 4'd9;
  localparam logic [3:0] OP_ROT1  = 4'd10;
  localparam logic [3:0] OP_ROT2  = 4'd11;
  localparam logic [3:0] OP_ROT3  = 4'd12;
  localparam logic [3:0] OP_NEWX  = 4'd13;
  localparam logic [3:0] OP_NEWY  = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] idx;
  } imi_cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
  } imi_emit_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/imi_ctrl.sv
// Sequencer for the Ikeda map iterator: warm-up and emit counting, per-iteration steps.
// Depends on imi_pkg; drives imi_dp through imi_cmd_t.
module imi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       warmup_steps,
  input  logic [6:0]        points_out,
  input  logic              out_free,
  output imi_pkg::imi_cmd_t cmd,
  output imi_pkg::imi_emit_t emit
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_PHASE = 4'd5;
  localparam logic [3:0] S_RED   = 4'd6;
  localparam logic [3:0] S_FOLD  = 4'd7;
  localparam logic [3:0] S_COR   = 4'd8;
  localparam logic [3:0] S_ROT0  = 4'd9;
  localparam logic [3:0] S_ROT1  = 4'd10;
  localparam logic [3:0] S_ROT2  = 4'd11;
  localparam logic [3:0] S_ROT3  = 4'd12;
  localparam logic [3:0] S_NEWX  = 4'd13;
  localparam logic [3:0] S_NEWY  = 4'd14;
  localparam logic [3:0] S_EMIT  = 4'd15;

  localparam logic [5:0] DIV_LAST = 6'(imi_pkg::NUM_W - 1);
  localparam logic [5:0] RED_LAST = 6'(imi_pkg::RED_STEPS - 1);
  localparam logic [5:0] COR_LAST = 6'(imi_pkg::CORDIC_STEPS - 1);
  localparam logic [6:0] MAXP     = 7'(imi_pkg::MAX_POINTS);

  logic [3:0]  state_r, state_nxt;
  logic [15:0] step_r, step_nxt;
  logic [6:0]  emit_r, emit_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        emode_r, emode_nxt;
  logic [6:0]  npts;
  logic [5:0]  red_k;

  always_comb begin
    if (points_out == 7'd0) begin
      npts = 7'd1;
    end else if (points_out > MAXP) begin
      npts = MAXP;
    end else begin
      npts = points_out;
    end
  end

  assign red_k    = RED_LAST - cnt_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    emit_nxt  = emit_r;
    cnt_nxt   = cnt_r;
    emode_nxt = emode_r;
    cmd.op    = imi_pkg::OP_NONE;
    cmd.idx   = cnt_r[4:0];
    emit.emit = 1'b0;
    emit.last = ((emit_r + 7'd1) == npts);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = imi_pkg::OP_LOAD;
          step_nxt  = 16'd0;
          emit_nxt  = 7'd0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cnt_nxt = 6'd0;
        if (step_r < warmup_steps) begin
          emode_nxt = 1'b0;
          state_nxt = S_SQX;
        end else if (emit_r < npts) begin
          emode_nxt = 1'b1;
          state_nxt = S_SQX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQX: begin
        cmd.op    = imi_pkg::OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = imi_pkg::OP_SQY;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = imi_pkg::OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.op    = imi_pkg::OP_PHASE;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.op  = imi_pkg::OP_RED;
        cmd.idx = red_k[4:0];
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == RED_LAST) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.op    = imi_pkg::OP_FOLD;
        state_nxt = S_COR;
      end
      S_COR: begin
        cmd.op  = imi_pkg::OP_COR;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == COR_LAST) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_ROT0;
        end
      end
      S_ROT0: begin
        cmd.op    = imi_pkg::OP_ROT0;
        state_nxt = S_ROT1;
      end
      S_ROT1: begin
        cmd.op    = imi_pkg::OP_ROT1;
        state_nxt = S_ROT2;
      end
      S_ROT2: begin
        cmd.op    = imi_pkg::OP_ROT2;
        state_nxt = S_ROT3;
      end
      S_ROT3: begin
        cmd.op    = imi_pkg::OP_ROT3;
        state_nxt = S_NEWX;
      end
      S_NEWX: begin
        cmd.op    = imi_pkg::OP_NEWX;
        state_nxt = S_NEWY;
      end
      S_NEWY: begin
        cmd.op = imi_pkg::OP_NEWY;
        if (emode_r) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt  = step_r + 16'd1;
          state_nxt = S_START;
        end
      end
      S_EMIT: begin
        // The new x waits here until the output register can take it.
        if (out_free) begin
          emit.emit = 1'b1;
          emit_nxt  = emit_r + 7'd1;
          state_nxt = S_START;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 16'd0;
      emit_r  <= 7'd0;
      cnt_r   <= 6'd0;
      emode_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      emit_r  <= emit_nxt;
      cnt_r   <= cnt_nxt;
      emode_r <= emode_nxt;
    end
  end

endmodule

// File: rtl/core/imi_dp.sv
// Datapath for one Ikeda map iteration: shared multiplier, restoring divider,
// angle reduction and CORDIC. Depends on imi_pkg; commanded by imi_ctrl.
module imi_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  imi_pkg::imi_cmd_t   cmd,
  input  logic signed [31:0]  in_start_x,
  input  logic signed [31:0]  in_start_y,
  input  logic signed [31:0]  in_param_a,
  input  logic signed [31:0]  gain_b,
  input  logic signed [31:0]  offset_c,
  input  logic signed [31:0]  phase_d,
  output logic signed [31:0]  cur_x,
  output logic                sat_seen
);

  localparam int CW = imi_pkg::CW;
  localparam logic [imi_pkg::DEN_W-1:0] DEN_ONE = imi_pkg::DEN_W'(1) << imi_pkg::FRAC_BITS;

  logic signed [31:0] x_r, y_r, a_r;
  logic signed [65:0] acc_r;
  logic [imi_pkg::DEN_W-1:0] den_r, rem_r;
  logic [imi_pkg::NUM_W-1:0] num_r;
  logic [31:0] quot_r;
  logic [imi_pkg::RED_W-1:0] red_r;
  logic zneg_r, ncos_r, sat_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic signed [32:0] rx_r, ry_r;

  logic signed [32:0] ma, mb, cs33, sn33;
  logic signed [CW-1:0] cs;
  logic signed [65:0] prod, sq_sum, rot_v, upd_v;
  logic [31:0] dm;
  logic [imi_pkg::DEN_W:0] rem_sh;
  logic div_ge;
  logic signed [33:0] qs, tv;
  logic [39:0] z40;
  logic [imi_pkg::RED_W-1:0] red_lim;
  logic signed [34:0] zs, za, zf;
  logic fold_neg;
  logic signed [CW-1:0] sx, sy, at;
  logic rot_hi, rot_lo, upd_hi, upd_lo;
  logic signed [32:0] rot_c;
  logic signed [31:0] upd_c;

  assign cs   = ncos_r ? -cx_r : cx_r;
  assign cs33 = cs[32:0];
  assign sn33 = cy_r[32:0];

  always_comb begin
    ma = {x_r[31], x_r};
    mb = {x_r[31], x_r};
    case (cmd.op)
      imi_pkg::OP_SQY: begin
        ma = {y_r[31], y_r};
        mb = {y_r[31], y_r};
      end
      imi_pkg::OP_ROT0: mb = cs33;
      imi_pkg::OP_ROT1: begin
        ma = {y_r[31], y_r};
        mb = sn33;
      end
      imi_pkg::OP_ROT2: mb = sn33;
      imi_pkg::OP_ROT3: begin
        ma = {y_r[31], y_r};
        mb = cs33;
      end
      imi_pkg::OP_NEWX: begin
        ma = {gain_b[31], gain_b};
        mb = rx_r;
      end
      imi_pkg::OP_NEWY: begin
        ma = {gain_b[31], gain_b};
        mb = ry_r;
      end
      default: ;
    endcase
  end

  assign prod   = ma * mb;
  assign sq_sum = acc_r + prod;
  assign dm     = phase_d[31] ? (~phase_d + 32'd1) : phase_d;

  // One restoring division step: one quotient bit a cycle.
  assign rem_sh = {rem_r, num_r[imi_pkg::NUM_W-1]};
  assign div_ge = (rem_sh >= {1'b0, den_r});

  assign qs  = phase_d[31] ? -$signed({2'b00, quot_r}) : $signed({2'b00, quot_r});
  assign tv  = $signed({{2{offset_c[31]}}, offset_c}) - qs;
  assign z40 = {tv, {imi_pkg::ANG_SHIFT{1'b0}}};

  assign red_lim = imi_pkg::TWO_PI_R << cmd.idx[2:0];

  // Remainder keeps the sign of the angle; then fold into [-pi/2, pi/2].
  always_comb begin
    zs = zneg_r ? -$signed({2'b00, red_r[32:0]}) : $signed({2'b00, red_r[32:0]});
    if (zs > imi_pkg::PI_A) begin
      za = zs - imi_pkg::TWO_PI_A;
    end else if (zs < -imi_pkg::PI_A) begin
      za = zs + imi_pkg::TWO_PI_A;
    end else begin
      za = zs;
    end
    fold_neg = 1'b0;
    zf = za;
    if (za > imi_pkg::HALF_PI_A) begin
      zf = imi_pkg::PI_A - za;
      fold_neg = 1'b1;
    end else if (za < -imi_pkg::HALF_PI_A) begin
      zf = -imi_pkg::PI_A - za;
      fold_neg = 1'b1;
    end
  end

  assign sx = cx_r >>> cmd.idx;
  assign sy = cy_r >>> cmd.idx;
  assign at = $signed({2'b00, imi_pkg::atan_val(cmd.idx)});

  assign rot_v  = ((cmd.op == imi_pkg::OP_ROT1) ? (acc_r - prod) : (acc_r + prod))
                  >>> imi_pkg::ANG_BITS;
  assign rot_hi = (rot_v > imi_pkg::ROT_LIM);
  assign rot_lo = (rot_v < -imi_pkg::ROT_LIM);
  assign rot_c  = rot_hi ? imi_pkg::ROT_LIM[32:0] :
                  rot_lo ? 33'(-imi_pkg::ROT_LIM) : rot_v[32:0];

  assign upd_v  = ((cmd.op == imi_pkg::OP_NEWX) ? $signed({{34{a_r[31]}}, a_r}) : 66'sd0)
                  + (prod >>> imi_pkg::FRAC_BITS);
  assign upd_hi = (upd_v > imi_pkg::INT_MAX_W);
  assign upd_lo = (upd_v < imi_pkg::INT_MIN_W);
  assign upd_c  = upd_hi ? imi_pkg::INT_MAX_W[31:0] :
                  upd_lo ? imi_pkg::INT_MIN_W[31:0] : upd_v[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.op == imi_pkg::OP_LOAD) begin
      sat_r <= 1'b0;
    end else if (((cmd.op == imi_pkg::OP_ROT1) || (cmd.op == imi_pkg::OP_ROT3)) &&
                 (rot_hi || rot_lo)) begin
      sat_r <= 1'b1;
    end else if (((cmd.op == imi_pkg::OP_NEWX) || (cmd.op == imi_pkg::OP_NEWY)) &&
                 (upd_hi || upd_lo)) begin
      sat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      imi_pkg::OP_LOAD: begin
        x_r <= in_start_x;
        y_r <= in_start_y;
        a_r <= in_param_a;
      end
      imi_pkg::OP_SQX: acc_r <= prod;
      imi_pkg::OP_SQY: begin
        den_r  <= sq_sum[imi_pkg::FRAC_BITS+imi_pkg::DEN_W-1:imi_pkg::FRAC_BITS] + DEN_ONE;
        num_r  <= {dm, {imi_pkg::FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        quot_r <= '0;
      end
      imi_pkg::OP_DIV: begin
        rem_r  <= div_ge ? imi_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                         : rem_sh[imi_pkg::DEN_W-1:0];
        num_r  <= {num_r[imi_pkg::NUM_W-2:0], 1'b0};
        quot_r <= {quot_r[30:0], div_ge};
      end
      imi_pkg::OP_PHASE: begin
        zneg_r <= z40[39];
        red_r  <= z40[39] ? (~z40 + 40'd1) : z40;
      end
      imi_pkg::OP_RED: begin
        if (red_r >= red_lim) begin
          red_r <= red_r - red_lim;
        end
      end
      imi_pkg::OP_FOLD: begin
        cx_r   <= imi_pkg::CORDIC_K;
        cy_r   <= '0;
        cz_r   <= zf[CW-1:0];
        ncos_r <= fold_neg;
      end
      imi_pkg::OP_COR: begin
        if (!cz_r[CW-1]) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          cz_r <= cz_r + at;
        end
      end
      imi_pkg::OP_ROT0: acc_r <= prod;
      imi_pkg::OP_ROT1: rx_r  <= rot_c;
      imi_pkg::OP_ROT2: acc_r <= prod;
      imi_pkg::OP_ROT3: ry_r  <= rot_c;
      imi_pkg::OP_NEWX: x_r   <= upd_c;
      imi_pkg::OP_NEWY: y_r   <= upd_c;
      default: ;
    endcase
  end

  assign cur_x    = x_r;
  assign sat_seen = sat_r;

endmodule

// File: rtl/core/ikeda_map_iterator_core.sv
// Ikeda map iterator top level: configuration registers, output register, sequencer and datapath.
// Each map iteration steps through the multiplies, the bit-serial divider, angle reduction and
// CORDIC in turn; an emitted point then waits until the output register is free.
// Start points are handled one at a time: a new one is taken only while the sequencer is idle.
// Reset (synchronous, rst_n low) sets the registers to their defaults and empties the output.
// Depends on imi_pkg, imi_ctrl and imi_dp.
module ikeda_map_iterator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_param_a,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_value,
  output logic               out_last_point,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic signed [31:0] gain_b_r, offset_c_r, phase_d_r;
  logic [15:0] warmup_r;
  logic [6:0]  points_r;
  logic        out_valid_r;
  logic signed [31:0] out_x_r;
  logic        out_last_r, out_sat_r;
  logic        out_free;
  logic signed [31:0] dp_x;
  logic        dp_sat;
  imi_pkg::imi_cmd_t  cmd;
  imi_pkg::imi_emit_t emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_b_r   <= imi_pkg::GAIN_B_RST;
      offset_c_r <= imi_pkg::OFFSET_C_RST;
      phase_d_r  <= imi_pkg::PHASE_D_RST;
      warmup_r   <= imi_pkg::WARMUP_RST;
      points_r   <= imi_pkg::POINTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        imi_pkg::REG_GAIN_B:   gain_b_r   <= cfg_wdata;
        imi_pkg::REG_OFFSET_C: offset_c_r <= cfg_wdata;
        imi_pkg::REG_PHASE_D:  phase_d_r  <= cfg_wdata;
        imi_pkg::REG_WARMUP:   warmup_r   <= cfg_wdata[15:0];
        imi_pkg::REG_POINTS:   points_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  imi_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .warmup_steps (warmup_r),
    .points_out   (points_r),
    .out_free     (out_free),
    .cmd          (cmd),
    .emit         (emit)
  );

  imi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_param_a (in_param_a),
    .gain_b     (gain_b_r),
    .offset_c   (offset_c_r),
    .phase_d    (phase_d_r),
    .cur_x      (dp_x),
    .sat_seen   (dp_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit) begin
      out_x_r    <= dp_x;
      out_last_r <= emit.last;
      out_sat_r  <= dp_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x_value    = out_x_r;
  assign out_last_point = out_last_r;
  assign out_saturated  = out_sat_r;

  // A request that is taken starts a run, so the input side is busy next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after a request was taken");

  // A result is only produced while a run is in progress.
  a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit.emit |-> in_stall)
    else $error("result produced with the sequencer idle");

  // A held result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !emit.emit)
    else $error("pending result overwritten");

endmodule

// File: dv/ikeda_map_iterator_core_tb.sv
// Self-checking testbench for ikeda_map_iterator_core: directed and random start points
// through several register settings, predicted by an independent fixed-point Ikeda map.
// Depends on imi_pkg and the ikeda_map_iterator_core RTL.
`timescale 1ns / 100ps

module ikeda_map_iterator_core_tb;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] pa;
  } start_req_t;

  typedef struct {
    logic signed [31:0] xv;
    logic               last;
    logic               sat;
  } orbit_pt_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic signed [31:0] in_param_a = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] out_x_value;
  logic               out_last_point;
  logic               out_saturated;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = imi_pkg::REG_GAIN_B;
  logic [31:0]        cfg_wdata = '0;

  start_req_t  start_q[$];
  orbit_pt_t   orbit_q[$];

  // Shadow copy of the block's registers.
  logic signed [31:0] gain_r = imi_pkg::GAIN_B_RST;
  logic signed [31:0] offs_r = imi_pkg::OFFSET_C_RST;
  logic signed [31:0] phase_r = imi_pkg::PHASE_D_RST;
  logic [15:0]        warm_r = imi_pkg::WARMUP_RST;
  logic [6:0]         pts_r = imi_pkg::POINTS_RST;

  longint orb_x, orb_y;
  bit     orb_sat;

  int send_pct = 31;
  int recv_pct = 47;
  int fails = 0;
  int points_seen = 0;
  int starts_sent = 0;
  int starts_pushed = 0;
  int sat_points = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  ikeda_map_iterator_core dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clip_val(input longint v, input longint lo, input longint hi,
                                      inout bit flag);
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // One map step on orb_x/orb_y with the current register shadow.
  task automatic ikeda_step(input longint a);
    longint x, y, d, t, z, cx, cy, nx, sn, cs, rx, ry, q;
    longint unsigned den, dm, qm;
    bit neg_cos;
    x = orb_x;
    y = orb_y;
    d = phase_r;
    den = ((longint'(x * x) + longint'(y * y)) >> imi_pkg::FRAC_BITS)
          + (64'd1 << imi_pkg::FRAC_BITS);
    dm = (d < 0) ? longint'(-d) : d;
    qm = (dm << imi_pkg::FRAC_BITS) / den;
    q = (d < 0) ? -longint'(qm) : longint'(qm);
    t = longint'(offs_r) - q;
    z = t * 64;
    z = z % longint'(imi_pkg::TWO_PI_A);
    if (z > longint'(imi_pkg::PI_A)) z -= longint'(imi_pkg::TWO_PI_A);
    if (z < -longint'(imi_pkg::PI_A)) z += longint'(imi_pkg::TWO_PI_A);
    neg_cos = 1'b0;
    if (z > longint'(imi_pkg::HALF_PI_A)) begin
      z = longint'(imi_pkg::PI_A) - z;
      neg_cos = 1'b1;
    end else if (z < -longint'(imi_pkg::HALF_PI_A)) begin
      z = -longint'(imi_pkg::PI_A) - z;
      neg_cos = 1'b1;
    end
    cx = longint'(imi_pkg::CORDIC_K);
    cy = 0;
    for (int i = 0; i < imi_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= longint'(imi_pkg::atan_val(i[4:0]));
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += longint'(imi_pkg::atan_val(i[4:0]));
      end
      cx = nx;
    end
    sn = cy;
    cs = neg_cos ? -cx : cx;
    rx = (x * cs - y * sn) >>> imi_pkg::ANG_BITS;
    ry = (x * sn + y * cs) >>> imi_pkg::ANG_BITS;
    rx = clip_val(rx, -64'sd4294967295, 64'sd4294967295, orb_sat);
    ry = clip_val(ry, -64'sd4294967295, 64'sd4294967295, orb_sat);
    orb_x = clip_val(a + ((longint'(gain_r) * rx) >>> imi_pkg::FRAC_BITS),
                     -64'sd2147483648, 64'sd2147483647, orb_sat);
    orb_y = clip_val((longint'(gain_r) * ry) >>> imi_pkg::FRAC_BITS,
                     -64'sd2147483648, 64'sd2147483647, orb_sat);
  endtask

  task automatic predict_orbit(input start_req_t r);
    int n;
    orbit_pt_t p;
    n = pts_r;
    if (n < 1) n = 1;
    if (n > imi_pkg::MAX_POINTS) n = imi_pkg::MAX_POINTS;
    orb_x = r.sx;
    orb_y = r.sy;
    orb_sat = 1'b0;
    for (int i = 0; i < warm_r; i++) ikeda_step(r.pa);
    for (int i = 0; i < n; i++) begin
      ikeda_step(r.pa);
      p.xv = orb_x[31:0];
      p.last = (i == n - 1);
      p.sat = orb_sat;
      orbit_q.push_back(p);
    end
  endtask

  // Driver: a request is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_orbit('{in_start_x, in_start_y, in_param_a});
        starts_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (start_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          start_req_t r;
          r = start_q.pop_front();
          in_valid <= 1'b1;
          in_start_x <= r.sx;
          in_start_y <= r.sy;
          in_param_a <= r.pa;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted point against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        points_seen++;
        if (out_saturated) sat_points++;
        if (orbit_q.size() == 0) begin
          $display("%0t: unexpected point x=%h last=%b sat=%b", $time, out_x_value,
                   out_last_point, out_saturated);
          fails++;
        end else begin
          orbit_pt_t e;
          e = orbit_q.pop_front();
          if (e.xv !== out_x_value) begin
            $display("%0t: x_value expected %h actual %h", $time, e.xv, out_x_value);
            fails++;
          end
          if (e.last !== out_last_point) begin
            $display("%0t: last_point expected %b actual %b", $time, e.last, out_last_point);
            fails++;
          end
          if (e.sat !== out_saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, out_saturated);
            fails++;
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 3000;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      imi_pkg::REG_GAIN_B:   gain_r = val;
      imi_pkg::REG_OFFSET_C: offs_r = val;
      imi_pkg::REG_PHASE_D:  phase_r = val;
      imi_pkg::REG_WARMUP:   warm_r = val[15:0];
      imi_pkg::REG_POINTS:   pts_r = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] b, c, d, w, n);
    write_reg(imi_pkg::REG_GAIN_B, b);
    write_reg(imi_pkg::REG_OFFSET_C, c);
    write_reg(imi_pkg::REG_PHASE_D, d);
    write_reg(imi_pkg::REG_WARMUP, w);
    write_reg(imi_pkg::REG_POINTS, n);
  endtask

  task automatic push_start(input logic [31:0] x, y, a);
    start_q.push_back('{x, y, a});
    starts_pushed++;
  endtask

  task automatic drain;
    // Every queued request must have been taken and every predicted point seen.
    while (starts_sent != starts_pushed || orbit_q.size() != 0) @(posedge clk);
    // Let the core settle before the next register writes.
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] near_val();
    // Mostly values within about +-4.0, now and then any 32-bit pattern.
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
    return $urandom;
  endfunction

  task automatic push_random(input int cnt);
    for (int i = 0; i < cnt; i++) push_start(near_val(), near_val(), near_val());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults, long warm-up.
    push_start(32'h0, 32'h0, 32'h0);
    push_start(32'h0019_999A, 32'hFFE6_6666, 32'h0100_0000);
    drain();

    // Extreme registers, zero warm-up, points_out of zero gives one point.
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
    push_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_start(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    push_start(32'h0, 32'h0, 32'h7FFF_FFFF);
    push_start(32'h0100_0000, 32'h0, 32'h0);
    drain();

    // Opposite extremes, points_out above the limit gives the maximum.
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd127);
    push_start(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_start(32'h0000_0001, 32'hFFFF_FFFF, 32'h0100_0000);
    push_start(32'h0, 32'h0, 32'h0);
    drain();

    write_all(32'h0, 32'h0, 32'h0, 32'd65535 & 32'd3, 32'd64);
    push_start(32'h0123_4567, 32'hFEDC_BA98, 32'h0080_0000);
    drain();

    // Classic parameters, sender 31% idle, receiver 47%.
    write_all(imi_pkg::GAIN_B_RST, imi_pkg::OFFSET_C_RST, imi_pkg::PHASE_D_RST, 32'd2, 32'd8);
    push_random(30);
    drain();

    // Random registers, idling swapped.
    send_pct = 47;
    recv_pct = 31;
    write_all(near_val(), near_val(), near_val(), $urandom_range(0, 4), $urandom_range(1, 16));
    push_random(15);
    drain();
    write_all($urandom, $urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 127));
    push_random(10);
    drain();

    // No idling, with one long receiver hold-off so the core backs up.
    send_pct = 0;
    recv_pct = 0;
    write_all(imi_pkg::GAIN_B_RST, imi_pkg::OFFSET_C_RST, imi_pkg::PHASE_D_RST, 32'd1, 32'd3);
    push_random(30);
    hold_go = 1'b1;
    drain();

    $display("Run covered %0d start points and %0d orbit points (%0d saturated)",
             starts_sent, points_seen, sat_points);
    $display("over extreme, default and random register settings with idle and backpressure.");
    if (fails == 0 && orbit_q.size() == 0) begin
      $display("** ikeda_map_iterator_core: PASSED **");
    end else begin
      $display("** ikeda_map_iterator_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d points still expected", orbit_q.size());
    $display("** ikeda_map_iterator_core: FAILED **");
    $finish;
  end

endmodule
